[src/hsv2rgb_pkg.sv]
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Shared widths, fixed-point constants and pipeline control type for the
// HSV to RGB converter.
// ----------------------------------------------------------------------------
`default_nettype none

package hsv2rgb_pkg;

    // input word layout
    localparam int HUE_W     = 13;
    localparam int PCT_W     = 11;
    localparam int IN_DATA_W = 40;

    localparam int SEC_W   = 3;
    localparam int DIST_W  = 10;
    localparam int SV_W    = 2 * PCT_W;
    localparam int PROD_W  = 32;

    // six register stages: two in the top level, four in each channel scaler
    localparam int PIPE_DEPTH = 6;
    localparam int STG_DIFF   = 2;
    localparam int STG_ROUND  = 3;
    localparam int STG_EST    = 4;
    localparam int STG_OUT    = 5;

    localparam logic [DIST_W-1:0] HUE_SECTOR = 10'd960;
    localparam int                HUE_WRAPS  = 8;

    // 1600 * 960: weight of v in the common numerator
    localparam logic [20:0] V_SCALE = 21'd1536000;

    // full-scale denominator 1600 * 1600 * 960 = 2^18 * 9375
    localparam logic [PROD_W-1:0] DEN       = 32'd2457600000;
    localparam logic [PROD_W-1:0] HALF_DEN  = 32'd1228800000;
    localparam int                DEN_SHIFT = 18;
    localparam int                ODD_W     = 14;
    localparam logic [ODD_W-1:0]  DEN_ODD   = 14'd9375;

    typedef struct packed {
        logic [PIPE_DEPTH-1:0] en;
        logic [PIPE_DEPTH-1:0] vld;
    } pipe_ctl_t;

endpackage

`default_nettype wire

[src/hsv2rgb_scale.sv]
// ----------------------------------------------------------------------------
// hsv2rgb_scale
// One output channel: clamp the exact numerator, scale it to full scale and
// divide by the fixed denominator with round to nearest (four stages).
// ----------------------------------------------------------------------------
`default_nettype none

module hsv2rgb_scale #(
    parameter int OUT_BITS = 12
) (
    input  wire logic                        aclk,
    input  wire hsv2rgb_pkg::pipe_ctl_t      ctl,
    input  wire logic [hsv2rgb_pkg::PROD_W-1:0] vterm,
    input  wire logic [hsv2rgb_pkg::PROD_W-1:0] prod,
    output logic [OUT_BITS-1:0]              level
);
    import hsv2rgb_pkg::*;

    localparam int NS_W   = OUT_BITS + ODD_W;
    localparam int REC_W  = OUT_BITS + 1;
    localparam int FULL_W = PROD_W + OUT_BITS;
    localparam int REM_W  = ODD_W + 1;
    localparam longint unsigned REC_L = (64'd1 << NS_W) / 64'd9375;
    localparam logic [REC_W-1:0] RECIP = REC_W'(REC_L);

    logic [PROD_W-1:0]   n_reg,  n_next;
    logic [NS_W-1:0]     ns_d_reg, ns_d_next;
    logic [NS_W-1:0]     ns_e_reg;
    logic [REC_W-1:0]    q0_reg, q0_next;
    logic [OUT_BITS-1:0] level_reg, level_next;

    logic [PROD_W:0]         diff;
    logic [FULL_W-1:0]       full;
    logic [NS_W+REC_W-1:0]   est;
    logic [NS_W:0]           back;
    logic [NS_W:0]           rem;
    logic [REM_W-1:0]        rem_lo;
    logic [REC_W-1:0]        q_fix;

    // clamp numerator into 0..DEN
    always_comb begin
        diff = {1'b0, vterm} - {1'b0, prod};
        if (diff[PROD_W]) begin
            n_next = '0;
        end else if (diff[PROD_W-1:0] > DEN) begin
            n_next = DEN;
        end else begin
            n_next = diff[PROD_W-1:0];
        end
    end

    // n * (2^OUT_BITS - 1) + DEN/2, then drop the power-of-two part of DEN
    always_comb begin
        full = {n_reg, {OUT_BITS{1'b0}}} - FULL_W'(n_reg) + FULL_W'(HALF_DEN);
        ns_d_next = full[FULL_W-1:DEN_SHIFT];
    end

    // reciprocal estimate, low by at most one
    always_comb begin
        est     = (NS_W+REC_W)'(ns_d_reg) * (NS_W+REC_W)'(RECIP);
        q0_next = est[NS_W+REC_W-1:NS_W];
    end

    // fix up the estimate with one compare
    always_comb begin
        back   = (NS_W+1)'(q0_reg) * (NS_W+1)'(DEN_ODD);
        rem    = {1'b0, ns_e_reg} - back;
        rem_lo = rem[REM_W-1:0];
        q_fix  = q0_reg + ((rem_lo >= REM_W'(DEN_ODD)) ? REC_W'(1) : REC_W'(0));
        level_next = q_fix[OUT_BITS-1:0];
    end

    always_ff @(posedge aclk) begin
        if (ctl.en[STG_DIFF]) begin
            n_reg <= n_next;
        end
        if (ctl.en[STG_ROUND]) begin
            ns_d_reg <= ns_d_next;
        end
        if (ctl.en[STG_EST]) begin
            ns_e_reg <= ns_d_reg;
            q0_reg   <= q0_next;
        end
        if (ctl.en[STG_OUT]) begin
            level_reg <= level_next;
        end
    end

    assign level = level_reg;

endmodule

`default_nettype wire

[src/hsv_to_rgb_convert.sv]
// ----------------------------------------------------------------------------
// hsv_to_rgb_convert
// HSV to RGB colour conversion, one pixel per word, fully pipelined.
// ----------------------------------------------------------------------------
// Path: stage A, stage B, then the scaler's diff, round, estimate and output stages.
// Throughput: one word per cycle; six register stages, one multiplier deep.
// Stalls only when all six stages hold words and the output is not taken.
// Reset: aresetn (synchronous, active low) clears all stage valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_to_rgb_convert #(
    parameter int OUT_BITS = 12
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // hue[12:0], saturation[23:13], brightness[34:24], zero pad
    input  wire logic [hsv2rgb_pkg::IN_DATA_W-1:0] s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // red, green, blue (OUT_BITS each from bit 0 up), zero pad
    output logic [((3*OUT_BITS+7)/8)*8-1:0]        m_tdata
);
    import hsv2rgb_pkg::*;

    localparam int OUT_W = ((3 * OUT_BITS + 7) / 8) * 8;

    localparam logic [1:0] ROLE_BIG  = 2'd0;
    localparam logic [1:0] ROLE_MID  = 2'd1;
    localparam logic [1:0] ROLE_ZERO = 2'd2;

    logic [PIPE_DEPTH-1:0] vld_reg, vld_next;
    logic [PIPE_DEPTH-1:0] en;
    pipe_ctl_t             ctl;

    logic [HUE_W-1:0] hue_in;
    logic [PCT_W-1:0] sat_in;
    logic [PCT_W-1:0] bri_in;

    logic [SEC_W-1:0]  sec_a_reg, sec_a_next;
    logic [DIST_W-1:0] kc_a_reg,  kc_a_next;
    logic [SV_W-1:0]   sv_a_reg,  sv_a_next;
    logic [PCT_W-1:0]  v_a_reg;

    logic [2:0][PROD_W-1:0] prod_b_reg, prod_b_next;
    logic [PROD_W-1:0]      vterm_b_reg, vterm_b_next;

    logic [3:0]        wrap_idx;
    logic [HUE_W-1:0]  hue_base;
    logic [HUE_W-1:0]  hue_rem;
    logic [2:0][1:0]   roles;
    logic [2:0][OUT_BITS-1:0] chan_level;

    assign hue_in = s_tdata[HUE_W-1:0];
    assign sat_in = s_tdata[HUE_W+PCT_W-1:HUE_W];
    assign bri_in = s_tdata[HUE_W+2*PCT_W-1:HUE_W+PCT_W];

    // per-stage enable: load when empty or when the next stage moves on
    always_comb begin
        en[PIPE_DEPTH-1] = !vld_reg[PIPE_DEPTH-1] || m_tready;
        for (int i = PIPE_DEPTH - 2; i >= 0; i--) begin
            en[i] = !vld_reg[i] || en[i+1];
        end
        vld_next[0] = en[0] ? s_tvalid : vld_reg[0];
        for (int i = 1; i < PIPE_DEPTH; i++) begin
            vld_next[i] = en[i] ? vld_reg[i-1] : vld_reg[i];
        end
    end

    assign ctl.en  = en;
    assign ctl.vld = vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    // stage A: sector and position in one step over the wrapped hue range
    always_comb begin
        wrap_idx = '0;
        for (int j = 1; j <= HUE_WRAPS; j++) begin
            if (hue_in >= HUE_W'(j * int'(HUE_SECTOR))) begin
                wrap_idx = 4'(j);
            end
        end
        hue_base = HUE_W'(wrap_idx) * HUE_W'(HUE_SECTOR);
        hue_rem  = hue_in - hue_base;
        sec_a_next = (wrap_idx >= 4'd6) ? SEC_W'(wrap_idx - 4'd6) : SEC_W'(wrap_idx);
        // kc = 960 - k, the distance of the secondary channel from chroma
        kc_a_next = sec_a_next[0] ? hue_rem[DIST_W-1:0]
                                  : HUE_SECTOR - hue_rem[DIST_W-1:0];
        sv_a_next = SV_W'(sat_in) * SV_W'(bri_in);
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            sec_a_reg <= sec_a_next;
            kc_a_reg  <= kc_a_next;
            sv_a_reg  <= sv_a_next;
            v_a_reg   <= bri_in;
        end
    end

    // stage B: channel value = 1600*960*v - s*v*dist
    always_comb begin
        unique case (sec_a_reg)
            3'd0:    roles = {ROLE_ZERO, ROLE_MID,  ROLE_BIG};
            3'd1:    roles = {ROLE_ZERO, ROLE_BIG,  ROLE_MID};
            3'd2:    roles = {ROLE_MID,  ROLE_BIG,  ROLE_ZERO};
            3'd3:    roles = {ROLE_BIG,  ROLE_MID,  ROLE_ZERO};
            3'd4:    roles = {ROLE_BIG,  ROLE_ZERO, ROLE_MID};
            default: roles = {ROLE_MID,  ROLE_ZERO, ROLE_BIG};
        endcase
        for (int c = 0; c < 3; c++) begin
            unique case (roles[c])
                ROLE_BIG: prod_b_next[c] = '0;
                ROLE_MID: prod_b_next[c] = PROD_W'(sv_a_reg) * PROD_W'(kc_a_reg);
                default:  prod_b_next[c] = PROD_W'(sv_a_reg) * PROD_W'(HUE_SECTOR);
            endcase
        end
        vterm_b_next = PROD_W'(v_a_reg) * PROD_W'(V_SCALE);
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            prod_b_reg  <= prod_b_next;
            vterm_b_reg <= vterm_b_next;
        end
    end

    for (genvar c = 0; c < 3; c++) begin : g_chan
        hsv2rgb_scale #(
            .OUT_BITS(OUT_BITS)
        ) u_scale (
            .aclk  (aclk),
            .ctl   (ctl),
            .vterm (vterm_b_reg),
            .prod  (prod_b_reg[c]),
            .level (chan_level[c])
        );
    end

    assign s_tready = en[0];
    assign m_tvalid = vld_reg[PIPE_DEPTH-1];
    assign m_tdata  = {{(OUT_W - 3 * OUT_BITS){1'b0}}, chan_level[2], chan_level[1],
                       chan_level[0]};

    // input holds off only when every stage is full and the output is stalled
    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (vld_reg == {PIPE_DEPTH{1'b1}}) && !m_tready)
        else $error("input stalled with a free stage");

    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> vld_reg[0])
        else $error("accepted word did not enter the first stage");

    a_drain_bubble: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !vld_reg[PIPE_DEPTH-2] |=> !m_tvalid)
        else $error("output word repeated after being taken");

endmodule

`default_nettype wire

[verif/hsv_to_rgb_convert_tb.sv]
// ----------------------------------------------------------------------------
// hsv_to_rgb_convert_tb
// Self-checking bench for the HSV to RGB converter. A driver streams HSV words
// from a queue and a monitor predicts each RGB word on acceptance, then checks
// the results in order. Both sides idle and stall in random bursts.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_to_rgb_convert_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int OUT_BITS   = 12;
    localparam int OUT_DATA_W = ((3 * OUT_BITS + 7) / 8) * 8;
    localparam int IN_DATA_W  = hsv2rgb_pkg::IN_DATA_W;

    // hue in 1/16 degree, percentages in 1/16 percent
    localparam longint HUE_TURN   = 5760;
    localparam longint HUE_SIXTH  = 960;
    localparam longint PCT_ONE    = 1600;
    localparam longint COLOR_DEN  = PCT_ONE * PCT_ONE * HUE_SIXTH;
    localparam longint FULL_SCALE = (longint'(1) << OUT_BITS) - 1;

    localparam int RANDOM_WORDS = 1800;
    localparam int TAIL_WORDS   = 250;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int FLUSH_CYCLES = 16;
    localparam int REPORT_MAX   = 10;

    typedef struct packed {
        logic [10:0] bri;
        logic [10:0] sat;
        logic [12:0] hue;
    } hsv_word_t;

    typedef struct packed {
        logic [OUT_BITS-1:0] blue;
        logic [OUT_BITS-1:0] green;
        logic [OUT_BITS-1:0] red;
    } rgb_word_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    hsv_word_t pending_hsv[$];
    rgb_word_t expected_rgb[$];

    bit stream_on     = 1'b0;
    bit random_loaded = 1'b0;
    bit hsv_taken     = 1'b0;
    int cycles        = 0;
    int mismatches    = 0;
    int src_gap       = 0;
    int src_calm      = 0;
    int snk_gap       = 0;
    int snk_calm      = 0;

    hsv_to_rgb_convert #(
        .OUT_BITS(OUT_BITS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),   // hue[12:0], saturation[23:13], brightness[34:24], zero pad
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)    // red, green, blue (OUT_BITS each from bit 0 up), zero pad
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // clamp into 0..1.0 and round to nearest, halves up
    function automatic logic [OUT_BITS-1:0] channel_level(longint num);
        longint n;
        n = num;
        if (n < 0) n = 0;
        if (n > COLOR_DEN) n = COLOR_DEN;
        return OUT_BITS'((FULL_SCALE * n + COLOR_DEN / 2) / COLOR_DEN);
    endfunction

    function automatic rgb_word_t hsv_to_rgb(hsv_word_t hsv);
        longint h, s, v, sector, frac, k, chroma, second, offset;
        longint r, g, b;
        rgb_word_t rgb;
        h = hsv.hue;
        s = hsv.sat;
        v = hsv.bri;
        if (h >= HUE_TURN) h -= HUE_TURN;
        sector = h / HUE_SIXTH;
        frac   = h % HUE_SIXTH;
        k      = (sector % 2 == 1) ? HUE_SIXTH - frac : frac;
        chroma = s * v * HUE_SIXTH;
        second = s * v * k;
        offset = (PCT_ONE * v - s * v) * HUE_SIXTH;
        case (sector)
            0: begin r = chroma; g = second; b = 0;      end
            1: begin r = second; g = chroma; b = 0;      end
            2: begin r = 0;      g = chroma; b = second; end
            3: begin r = 0;      g = second; b = chroma; end
            4: begin r = second; g = 0;      b = chroma; end
            default: begin r = chroma; g = 0; b = second; end
        endcase
        rgb.red   = channel_level(r + offset);
        rgb.green = channel_level(g + offset);
        rgb.blue  = channel_level(b + offset);
        return rgb;
    endfunction

    task automatic add_hsv(int hue, int sat, int bri);
        hsv_word_t w;
        w.hue = 13'(hue);
        w.sat = 11'(sat);
        w.bri = 11'(bri);
        pending_hsv.push_back(w);
    endtask

    // driver: present words at the falling edge
    always @(negedge aclk) begin
        if (stream_on) begin
            if (s_tvalid && !hsv_taken) begin
                // hold the word until it is taken
            end else if (src_gap > 0) begin
                src_gap--;
                s_tvalid <= 1'b0;
            end else if (pending_hsv.size() == 0) begin
                s_tvalid <= 1'b0;
            end else if (!(random_loaded && pending_hsv.size() < TAIL_WORDS)
                         && src_calm == 0 && $urandom_range(0, 4) == 0) begin
                s_tvalid <= 1'b0;
                src_gap = $urandom_range(0, 12);
            end else begin
                s_tdata  <= IN_DATA_W'(pending_hsv.pop_front());
                s_tvalid <= 1'b1;
            end
            if (src_calm > 0) src_calm--;
            else if ($urandom_range(0, 63) == 0) src_calm = $urandom_range(30, 150);

            if (snk_gap > 0) begin
                snk_gap--;
                m_tready <= 1'b0;
            end else if (!(random_loaded && pending_hsv.size() < TAIL_WORDS)
                         && snk_calm == 0 && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                snk_gap = $urandom_range(0, 12);
            end else begin
                m_tready <= 1'b1;
            end
            if (snk_calm > 0) snk_calm--;
            else if ($urandom_range(0, 63) == 0) snk_calm = $urandom_range(30, 150);
        end
    end

    // monitor: predict on input accept, check on output accept
    always @(posedge aclk) begin
        rgb_word_t want, got;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[hsv_to_rgb_convert] ERROR");
            $finish;
        end else begin
            hsv_taken = 1'b0;
            if (aresetn && s_tvalid && s_tready) begin
                expected_rgb.push_back(hsv_to_rgb(hsv_word_t'(s_tdata[34:0])));
                hsv_taken = 1'b1;
            end
            if (aresetn && m_tvalid && m_tready) begin
                got = rgb_word_t'(m_tdata[3*OUT_BITS-1:0]);
                if (expected_rgb.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("cycle %0d: unexpected word r=%0d g=%0d b=%0d",
                                 cycles, got.red, got.green, got.blue);
                end else begin
                    want = expected_rgb.pop_front();
                    if (got.red !== want.red || got.green !== want.green
                        || got.blue !== want.blue) begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                            $display("cycle %0d: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                                     cycles, want.red, want.green, want.blue,
                                     got.red, got.green, got.blue);
                    end
                end
            end
        end
    end

    initial begin
        int i, pick, h, s, v;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn   = 1'b1;
        stream_on = 1'b1;

        // sector starts at full color
        for (i = 0; i < 6; i++) add_hsv(i * 960, 1600, 1600);
        add_hsv(480, 1600, 1600);
        add_hsv(5759, 1600, 1600);
        add_hsv(959, 1600, 1600);
        add_hsv(961, 800, 1600);
        add_hsv(0, 0, 0);
        add_hsv(3000, 0, 800);       // grey
        add_hsv(3000, 0, 1600);      // white
        add_hsv(1234, 1600, 0);      // black
        add_hsv(5760, 1600, 1600);   // wraps to red
        add_hsv(8191, 1600, 1600);   // largest hue, wraps once
        add_hsv(2000, 2047, 1600);   // saturation over range, negative offset
        add_hsv(4000, 0, 2047);      // brightness over range, clamps high
        add_hsv(8191, 2047, 2047);
        add_hsv(700, 1600, 2047);
        add_hsv(100, 1, 1);

        // wait until the pipe drains before queueing the random words
        while (pending_hsv.size() != 0 || s_tvalid || expected_rgb.size() != 0)
            @(posedge aclk);

        for (i = 0; i < RANDOM_WORDS; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
                h = $urandom_range(0, 8191);
                s = $urandom_range(0, 2047);
                v = $urandom_range(0, 2047);
            end else begin
                h = (pick < 25) ? $urandom_range(0, 5) * 960 + $urandom_range(0, 2) - 1
                                : $urandom_range(0, 5759);
                if (h < 0) h = 5759;
                case ($urandom_range(0, 7))
                    0: s = 0;
                    1: s = 1600;
                    default: s = $urandom_range(0, 1600);
                endcase
                case ($urandom_range(0, 7))
                    0: v = 0;
                    1: v = 1600;
                    default: v = $urandom_range(0, 1600);
                endcase
            end
            add_hsv(h, s, v);
        end
        random_loaded = 1'b1;

        while (pending_hsv.size() != 0 || s_tvalid || expected_rgb.size() != 0)
            @(posedge aclk);
        repeat (FLUSH_CYCLES) @(posedge aclk);

        if (mismatches == 0)
            $display("[hsv_to_rgb_convert] OK");
        else
            $display("[hsv_to_rgb_convert] ERROR");
        $finish;
    end

endmodule

`default_nettype wire
